@@ sv/hsv2rgb_pkg.sv @@
// hsv2rgb_pkg: constants shared by the hsv to rgb color converter
// hue sector size, full scale levels and reciprocal multipliers for the
// constant divisions; no dependencies
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned HueWidth   = 9;
  localparam int unsigned ChanWidth  = 8;
  localparam int unsigned RemWidth   = 6;
  localparam int unsigned SecWidth   = 3;

  // degrees per sector and per full turn
  localparam int unsigned HueSector  = 60;
  localparam int unsigned HueTurn    = 6 * HueSector;

  // levels are n/255, hue weighted levels are n/15300
  localparam int unsigned FullScale  = 255;
  localparam int unsigned HueFull    = HueSector * FullScale;

  // intermediate widths
  localparam int unsigned PNumWidth  = 2 * ChanWidth;  // v*(255-s)
  localparam int unsigned RsWidth    = 14;             // rem*s and (60-rem)*s, up to 15300
  localparam int unsigned QNumWidth  = ChanWidth + RsWidth;

  // floor(x/255) ~ (x*RecipP) >> RecipShiftP, low by at most one
  localparam int unsigned RecipShiftP = 24;
  localparam int unsigned RecipPWidth = 17;
  localparam logic [RecipPWidth-1:0] RecipP =
    RecipPWidth'((64'd1 << RecipShiftP) / FullScale);

  // floor(x/15300) ~ (x*RecipQ) >> RecipShiftQ, low by at most one
  localparam int unsigned RecipShiftQ = 36;
  localparam int unsigned RecipQWidth = 23;
  localparam logic [RecipQWidth-1:0] RecipQ =
    RecipQWidth'((64'd1 << RecipShiftQ) / HueFull);

  // sector codes
  localparam logic [SecWidth-1:0] SEC_RED_YEL   = 3'd0;
  localparam logic [SecWidth-1:0] SEC_YEL_GRN   = 3'd1;
  localparam logic [SecWidth-1:0] SEC_GRN_CYN   = 3'd2;
  localparam logic [SecWidth-1:0] SEC_CYN_BLU   = 3'd3;
  localparam logic [SecWidth-1:0] SEC_BLU_MAG   = 3'd4;
  localparam logic [SecWidth-1:0] SEC_MAG_RED   = 3'd5;

endpackage

`default_nettype wire

@@ sv/hsv_to_rgb_converter.sv @@
// hsv_to_rgb_converter: five stage pipelined hsv to rgb pixel conversion
// depends on hsv2rgb_pkg for constants and sector codes
`default_nettype none

//  channel | handshake                | payload
//  --------+--------------------------+---------------------------------
//  input   | in_valid / in_stall      | hue[8:0], saturation, value
//  output  | out_valid / out_stall    | red, green, blue (8 bits each)
//
// one item per clock sustained while out_stall is low; an accepted item
// reaches out_valid through the five register stages (hue decode, rem*s products,
// v*level products, reciprocal multiply, division correction and mux)
// rst is synchronous and clears only the stage valid bits
// each stage holds when it is full and the stage after it cannot take its
// item, so bubbles close up and a stalled output keeps its item
// in_stall rises only when every stage is full and out_stall is high

module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic [HueWidth-1:0]  hue,
  input  wire logic [ChanWidth-1:0] saturation,
  input  wire logic [ChanWidth-1:0] value,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic [ChanWidth-1:0] red,
  output      logic [ChanWidth-1:0] green,
  output      logic [ChanWidth-1:0] blue
);

  // ---------------------------------------------------------------
  // stage handshake: a stage loads when it is empty or moves on
  // ---------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !out_valid || !out_stall;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1        <= in_valid;
      if (rdy2) v2        <= v1;
      if (rdy3) v3        <= v2;
      if (rdy4) v4        <= v3;
      if (rdy5) out_valid <= v4;
    end
  end

  // ---------------------------------------------------------------
  // stage 1: split hue into sector and remainder, flag black
  // ---------------------------------------------------------------
  logic [SecWidth-1:0]  sec_in;
  logic [HueWidth-1:0]  base_in;
  logic                 black_in;

  always_comb begin
    black_in = (hue >= HueWidth'(HueTurn));
    // compare chain against the sector boundaries
    if (hue >= HueWidth'(5 * HueSector)) begin
      sec_in  = SEC_MAG_RED;
      base_in = HueWidth'(5 * HueSector);
    end else if (hue >= HueWidth'(4 * HueSector)) begin
      sec_in  = SEC_BLU_MAG;
      base_in = HueWidth'(4 * HueSector);
    end else if (hue >= HueWidth'(3 * HueSector)) begin
      sec_in  = SEC_CYN_BLU;
      base_in = HueWidth'(3 * HueSector);
    end else if (hue >= HueWidth'(2 * HueSector)) begin
      sec_in  = SEC_GRN_CYN;
      base_in = HueWidth'(2 * HueSector);
    end else if (hue >= HueWidth'(HueSector)) begin
      sec_in  = SEC_YEL_GRN;
      base_in = HueWidth'(HueSector);
    end else begin
      sec_in  = SEC_RED_YEL;
      base_in = '0;
    end
  end

  logic [SecWidth-1:0]  sec1;
  logic [RemWidth-1:0]  rem1;
  logic                 black1;
  logic [ChanWidth-1:0] sat1, val1;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      sec1   <= sec_in;
      rem1   <= RemWidth'(hue - base_in);
      black1 <= black_in;
      sat1   <= saturation;
      val1   <= value;
    end
  end

  // ---------------------------------------------------------------
  // stage 2: rem*s, (60-rem)*s and v*(255-s)
  // ---------------------------------------------------------------
  logic [RemWidth:0]    rem_c1;
  logic [RsWidth:0]     rs_t_full;

  always_comb begin
    rem_c1    = (RemWidth+1)'(HueSector) - {1'b0, rem1};
    rs_t_full = (RsWidth+1)'(rem_c1) * (RsWidth+1)'(sat1);
  end

  logic [SecWidth-1:0]  sec2;
  logic                 black2;
  logic [ChanWidth-1:0] val2;
  logic [PNumWidth-1:0] p_num2;
  logic [RsWidth-1:0]   rs_q2, rs_t2;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      sec2   <= sec1;
      black2 <= black1;
      val2   <= val1;
      p_num2 <= PNumWidth'(val1) * PNumWidth'(ChanWidth'(FullScale) - sat1);
      rs_q2  <= RsWidth'(rem1) * RsWidth'(sat1);
      rs_t2  <= RsWidth'(rs_t_full);
    end
  end

  // ---------------------------------------------------------------
  // stage 3: v*(15300-rem*s) and v*(15300-(60-rem)*s)
  // ---------------------------------------------------------------
  logic [RsWidth-1:0] qn2, tn2;

  always_comb begin
    qn2 = RsWidth'(HueFull) - rs_q2;
    tn2 = RsWidth'(HueFull) - rs_t2;
  end

  logic [SecWidth-1:0]  sec3;
  logic                 black3;
  logic [ChanWidth-1:0] val3;
  logic [PNumWidth-1:0] p_num3;
  logic [QNumWidth-1:0] q_num3, t_num3;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      sec3   <= sec2;
      black3 <= black2;
      val3   <= val2;
      p_num3 <= p_num2;
      q_num3 <= QNumWidth'(val2) * QNumWidth'(qn2);
      t_num3 <= QNumWidth'(val2) * QNumWidth'(tn2);
    end
  end

  // ---------------------------------------------------------------
  // stage 4: reciprocal multiply, estimate low by at most one
  // ---------------------------------------------------------------
  logic [PNumWidth+RecipPWidth-1:0] p_prod;
  logic [QNumWidth+RecipQWidth-1:0] q_prod, t_prod;

  always_comb begin
    p_prod = (PNumWidth+RecipPWidth)'(p_num3) * (PNumWidth+RecipPWidth)'(RecipP);
    q_prod = (QNumWidth+RecipQWidth)'(q_num3) * (QNumWidth+RecipQWidth)'(RecipQ);
    t_prod = (QNumWidth+RecipQWidth)'(t_num3) * (QNumWidth+RecipQWidth)'(RecipQ);
  end

  logic [SecWidth-1:0]  sec4;
  logic                 black4;
  logic [ChanWidth-1:0] val4;
  logic [PNumWidth-1:0] p_num4;
  logic [QNumWidth-1:0] q_num4, t_num4;
  logic [ChanWidth-1:0] pa4, qa4, ta4;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      sec4   <= sec3;
      black4 <= black3;
      val4   <= val3;
      p_num4 <= p_num3;
      q_num4 <= q_num3;
      t_num4 <= t_num3;
      pa4    <= p_prod[RecipShiftP +: ChanWidth];
      qa4    <= q_prod[RecipShiftQ +: ChanWidth];
      ta4    <= t_prod[RecipShiftQ +: ChanWidth];
    end
  end

  // ---------------------------------------------------------------
  // stage 5: one step correction, sector mux, output register
  // ---------------------------------------------------------------
  logic [PNumWidth-1:0] p_rem4;
  logic [QNumWidth-1:0] q_rem4, t_rem4;
  logic [ChanWidth-1:0] p4, q4, t4;
  logic [ChanWidth-1:0] red_next, green_next, blue_next;

  always_comb begin
    p_rem4 = p_num4 - PNumWidth'(PNumWidth'(pa4) * PNumWidth'(FullScale));
    q_rem4 = q_num4 - QNumWidth'(QNumWidth'(qa4) * QNumWidth'(HueFull));
    t_rem4 = t_num4 - QNumWidth'(QNumWidth'(ta4) * QNumWidth'(HueFull));
    p4 = (p_rem4 >= PNumWidth'(FullScale)) ? pa4 + ChanWidth'(1) : pa4;
    q4 = (q_rem4 >= QNumWidth'(HueFull))   ? qa4 + ChanWidth'(1) : qa4;
    t4 = (t_rem4 >= QNumWidth'(HueFull))   ? ta4 + ChanWidth'(1) : ta4;

    case (sec4)
      SEC_RED_YEL: begin
        red_next = val4; green_next = t4;   blue_next = p4;
      end
      SEC_YEL_GRN: begin
        red_next = q4;   green_next = val4; blue_next = p4;
      end
      SEC_GRN_CYN: begin
        red_next = p4;   green_next = val4; blue_next = t4;
      end
      SEC_CYN_BLU: begin
        red_next = p4;   green_next = q4;   blue_next = val4;
      end
      SEC_BLU_MAG: begin
        red_next = t4;   green_next = p4;   blue_next = val4;
      end
      default: begin
        red_next = val4; green_next = p4;   blue_next = q4;
      end
    endcase

    // hue out of range gives black
    if (black4) begin
      red_next   = '0;
      green_next = '0;
      blue_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------

  // input held off only when the whole pipe is full and blocked
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3 && v4 && out_valid && out_stall))
    else $error("in_stall with room in the pipeline");

  // reciprocal estimate of p is never more than one low
  a_p_recip: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (p_rem4 < PNumWidth'(2 * FullScale)))
    else $error("p reciprocal estimate off by more than one");

  // reciprocal estimates of q and t are never more than one low
  a_qt_recip: assert property (@(posedge clk) disable iff (rst)
    v4 |-> ((q_rem4 < QNumWidth'(2 * HueFull)) && (t_rem4 < QNumWidth'(2 * HueFull))))
    else $error("q or t reciprocal estimate off by more than one");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// testbench: self-checking regression for hsv_to_rgb_converter
// drives pixels over the valid/stall input, predicts rgb in exact integer math
// depends on hsv2rgb_pkg and hsv_to_rgb_converter
`default_nettype none

module testbench;
  import hsv2rgb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any handshake before the run is declared hung
  localparam int unsigned HangLimit   = 2000;
  // quiet cycles after the last result, well past the drain of the five stage pipeline
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned HoldOffCycles = 150;

  typedef struct packed {
    logic [ChanWidth-1:0] red;
    logic [ChanWidth-1:0] green;
    logic [ChanWidth-1:0] blue;
  } rgb_pixel_t;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [HueWidth-1:0]  hue        = '0;
  logic [ChanWidth-1:0] saturation = '0;
  logic [ChanWidth-1:0] value      = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [ChanWidth-1:0] red;
  logic [ChanWidth-1:0] green;
  logic [ChanWidth-1:0] blue;

  // rgb values still owed by the pipeline, oldest first
  rgb_pixel_t  pending_rgb[$];

  int unsigned error_count    = 0;
  int unsigned pixels_in      = 0;
  int unsigned pixels_out     = 0;
  int unsigned quiet_cycles   = 0;
  // per-cycle send idle and receive stall odds in percent, set by each test
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // long output hold-off, counted down by the stall process
  int unsigned holdoff_left   = 0;

  always #5 clk = ~clk;

  hsv_to_rgb_converter DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .hue        (hue),
    .saturation (saturation),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  // exact hsv to rgb: p, q and t are floor divisions of v times a weight
  function automatic rgb_pixel_t hsv_to_rgb_exact(logic [HueWidth-1:0] h,
                                                  logic [ChanWidth-1:0] s,
                                                  logic [ChanWidth-1:0] v);
    int unsigned hi, si, vi, rem, p, q, t;
    logic [SecWidth-1:0] sector;
    rgb_pixel_t px;
    hi = 32'(h);
    si = 32'(s);
    vi = 32'(v);
    px = '0;
    // hue past the last sector gives black
    if (hi < HueTurn) begin
      sector = SecWidth'(hi / HueSector);
      rem    = hi % HueSector;
      p = (vi * (FullScale - si)) / FullScale;
      q = (vi * (HueFull - rem * si)) / HueFull;
      t = (vi * (HueFull - (HueSector - rem) * si)) / HueFull;
      case (sector)
        SEC_RED_YEL: px = '{red: v,            green: t[7:0],       blue: p[7:0]};
        SEC_YEL_GRN: px = '{red: q[7:0],       green: v,            blue: p[7:0]};
        SEC_GRN_CYN: px = '{red: p[7:0],       green: v,            blue: t[7:0]};
        SEC_CYN_BLU: px = '{red: p[7:0],       green: q[7:0],       blue: v};
        SEC_BLU_MAG: px = '{red: t[7:0],       green: p[7:0],       blue: v};
        default:     px = '{red: v,            green: p[7:0],       blue: q[7:0]};
      endcase
    end
    return px;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // input side: every accepted pixel queues its predicted color
  // output side: every accepted color is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pending_rgb.push_back(hsv_to_rgb_exact(hue, saturation, value));
        pixels_in++;
      end
      if (out_valid && !out_stall) begin
        pixels_out++;
        if (pending_rgb.size() == 0) begin
          report_error($sformatf("color %0d,%0d,%0d with no pixel outstanding",
                                 red, green, blue));
        end else begin
          rgb_pixel_t want;
          want = pending_rgb.pop_front();
          if (red !== want.red)
            report_error($sformatf("red got %0d want %0d", red, want.red));
          if (green !== want.green)
            report_error($sformatf("green got %0d want %0d", green, want.green));
          if (blue !== want.blue)
            report_error($sformatf("blue got %0d want %0d", blue, want.blue));
        end
      end
    end
  end

  // output stall: the long hold-off wins, otherwise random at the phase's odds
  always @(posedge clk) begin
    logic hold;
    hold = 1'b0;
    if (holdoff_left > 0) begin
      holdoff_left--;
      hold = 1'b1;
    end else if ($urandom_range(99) < recv_stall_pct) begin
      hold = 1'b1;
    end
    out_stall <= hold;
  end

  // hang detector: counts cycles in which neither side moves an item
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= HangLimit) begin
      $display("hang: no item moved for %0d cycles", HangLimit);
      $display("Regression FAIL");
      $finish;
    end
  end

  // offer one pixel, maybe after random idle cycles, and wait until taken;
  // valid stays high afterwards so back-to-back items need no extra step
  task automatic send_pixel(input logic [HueWidth-1:0] h,
                            input logic [ChanWidth-1:0] s,
                            input logic [ChanWidth-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    hue        <= h;
    saturation <= s;
    value      <= v;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender goes quiet until every predicted color has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // sector edges, out-of-range hue, grey and black corners, all-ones fields
  task automatic test_corner_colors();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_pixel(9'd0,   8'd255, 8'd255);
    send_pixel(9'd59,  8'd255, 8'd255);
    send_pixel(9'd60,  8'd255, 8'd255);
    send_pixel(9'd119, 8'd255, 8'd255);
    send_pixel(9'd120, 8'd255, 8'd255);
    send_pixel(9'd179, 8'd255, 8'd255);
    send_pixel(9'd180, 8'd255, 8'd255);
    send_pixel(9'd239, 8'd255, 8'd255);
    send_pixel(9'd240, 8'd255, 8'd255);
    send_pixel(9'd299, 8'd255, 8'd255);
    send_pixel(9'd300, 8'd255, 8'd255);
    send_pixel(9'd359, 8'd255, 8'd255);
    // hue out of range is black, even at full value
    send_pixel(9'd360, 8'd255, 8'd255);
    send_pixel(9'd511, 8'd255, 8'd255);
    send_pixel(9'd511, 8'd0,   8'd0);
    // zero saturation is grey
    send_pixel(9'd45,  8'd0,   8'd200);
    send_pixel(9'd359, 8'd0,   8'd255);
    // zero value is black
    send_pixel(9'd200, 8'd255, 8'd0);
    send_pixel(9'd0,   8'd0,   8'd0);
    // mid-sector truncation cases
    send_pixel(9'd30,  8'd128, 8'd255);
    send_pixel(9'd150, 8'd1,   8'd254);
    send_pixel(9'd270, 8'd170, 8'd85);
    send_pixel(9'd330, 8'd254, 8'd1);
    wait_drained();
  endtask

  // random pixels: mostly legal hues, some near sector edges or out of range,
  // and saturation/value pulled toward the extremes now and then
  task automatic test_random_stream(input int unsigned count,
                                    input int unsigned idle_pct,
                                    input int unsigned stall_pct);
    logic [HueWidth-1:0]  h;
    logic [ChanWidth-1:0] s;
    logic [ChanWidth-1:0] v;
    int unsigned pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      pick = $urandom_range(9);
      if (pick == 0)
        h = HueWidth'($urandom_range(511, HueTurn));
      else if (pick == 1)
        h = HueWidth'($urandom_range(5) * HueSector + ($urandom_range(1) ? 0 : 59));
      else
        h = HueWidth'($urandom_range(HueTurn - 1));
      pick = $urandom_range(7);
      s = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : ChanWidth'($urandom());
      pick = $urandom_range(7);
      v = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : ChanWidth'($urandom());
      send_pixel(h, s, v);
    end
    wait_drained();
  endtask

  // receiver holds off for a long stretch while pixels keep coming, so the
  // pipeline fills and the block has to stall its input
  task automatic test_output_holdoff();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_left   = HoldOffCycles;
    repeat (40)
      send_pixel(HueWidth'($urandom_range(HueTurn - 1)),
                 ChanWidth'($urandom()), ChanWidth'($urandom()));
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_colors();
    test_random_stream(150, 0, 0);
    test_random_stream(150, 57, 0);
    test_output_holdoff();
    test_random_stream(150, 0, 57);
    test_random_stream(150, 21, 21);

    $display("%0d pixels sent, %0d colors checked: all six sectors and their edges,",
             pixels_in, pixels_out);
    $display("out-of-range hue, grey and black, idle and stall phases, long hold-off");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
sv/hsv2rgb_pkg.sv
sv/hsv_to_rgb_converter.sv
sim/testbench.sv
